@@ rtl/tspb_pkg.sv @@
package tspb_pkg;

   localparam int unsigned PATTERN_SIZE = 32;
   localparam int unsigned ROW_IDX_W    = $clog2(PATTERN_SIZE);
   localparam int unsigned CNT_W        = ROW_IDX_W + 1;
   localparam int unsigned LOG2_W       = 3;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 5;
   localparam logic [LOG2_W-1:0] MAX_LOG2 = 3'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE        = 3'd0,
      CSR_WIDTH_LOG2  = 3'd1,
      CSR_HEIGHT_LOG2 = 3'd2,
      CSR_X_OFFSET    = 3'd3,
      CSR_Y_OFFSET    = 3'd4
   } csr_index_type;

   typedef enum logic {
      MODE_TILE    = 1'b0,
      MODE_STIPPLE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [LOG2_W-1:0]     width_log2;
      logic [LOG2_W-1:0]     height_log2;
      logic [ROW_IDX_W-1:0]  x_offset;
      logic [ROW_IDX_W-1:0]  y_offset;
   } cfg_type;

endpackage

@@ rtl/tspb_if.sv @@
interface tspb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] source_word;

   modport source (output valid, output source_word, input ready);
   modport sink (input valid, input source_word, output ready);
endinterface

interface tspb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tspb_pkg::ROW_IDX_W-1:0]     row_index;
   logic [31:0]                        pattern_word;
   logic [31:0]                        fg_color;
   logic [31:0]                        bg_color;
   logic                               ok;
   logic                               last;

   modport source (output valid, output row_index, output pattern_word, output fg_color,
                   output bg_color, output ok, output last, input ready);
   modport sink (input valid, input row_index, input pattern_word, input fg_color,
                 input bg_color, input ok, input last, output ready);
endinterface

interface tspb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tspb_pkg::CSR_INDEX_W-1:0]    index;
   logic [tspb_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/tspb_csr_regs.sv @@
module tspb_csr_regs (
   input  logic              clock,
   input  logic              reset,
   tspb_csr_if.sink          csr_bus,
   output tspb_pkg::cfg_type cfg
);

   tspb_pkg::cfg_type cfg_ff;
   tspb_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (tspb_pkg::csr_index_type'(csr_bus.index))
            tspb_pkg::CSR_MODE: begin
               cfg_in.mode = tspb_pkg::mode_type'(csr_bus.data[0]);
            end
            tspb_pkg::CSR_WIDTH_LOG2: begin
               cfg_in.width_log2 = csr_bus.data[tspb_pkg::LOG2_W-1:0];
            end
            tspb_pkg::CSR_HEIGHT_LOG2: begin
               cfg_in.height_log2 = csr_bus.data[tspb_pkg::LOG2_W-1:0];
            end
            tspb_pkg::CSR_X_OFFSET: begin
               cfg_in.x_offset = csr_bus.data[tspb_pkg::ROW_IDX_W-1:0];
            end
            tspb_pkg::CSR_Y_OFFSET: begin
               cfg_in.y_offset = csr_bus.data[tspb_pkg::ROW_IDX_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= tspb_pkg::MODE_TILE;
         cfg_ff.width_log2  <= tspb_pkg::MAX_LOG2;
         cfg_ff.height_log2 <= tspb_pkg::MAX_LOG2;
         cfg_ff.x_offset    <= '0;
         cfg_ff.y_offset    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/tile_stipple_pattern_builder_core.sv @@
// Channel   Dir  Beat content
// req_bus   in   source_word: one pixel (tile mode) or one row word (stipple mode)
// rsp_bus   out  row_index, pattern_word, fg_color, bg_color, ok, last
// csr_bus   in   index, data: writes one configuration register, always ready
//
// An accepted beat is held in the input register and is folded into the
// row state in the next cycle; beats stream at one per cycle within a run.
// The beat that ends a run drops req ready; the 32 pattern rows then leave at
// one per cycle while rsp ready is high, each read straight from the row store
// into the result register. An error run ends in one beat instead.
// Reset clears all control state; the row store keeps whatever it held.
module tile_stipple_pattern_builder_core (
   input logic        clock,
   input logic        reset,
   tspb_req_if.sink   req_bus,
   tspb_rsp_if.source rsp_bus,
   tspb_csr_if.sink   csr_bus
);

   localparam int unsigned PS    = tspb_pkg::PATTERN_SIZE;
   localparam int unsigned IDX_W = tspb_pkg::ROW_IDX_W;
   localparam int unsigned CNT_W = tspb_pkg::CNT_W;

   function automatic logic [CNT_W-1:0] size_of(input logic [tspb_pkg::LOG2_W-1:0] lg);
      logic [tspb_pkg::LOG2_W-1:0] lim;
      lim = (lg > tspb_pkg::MAX_LOG2) ? tspb_pkg::MAX_LOG2 : lg;
      return CNT_W'(1) << lim;
   endfunction

   tspb_pkg::cfg_type cfg;

   tspb_csr_regs u_csr_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   logic             in_valid_ff;
   logic [PS-1:0]    in_word_ff;

   logic [PS-1:0]    acc_ff, acc_in;
   logic [31:0]      fg_ff, fg_in;
   logic [31:0]      bg_ff, bg_in;
   logic             fg_seen_ff, fg_seen_in;
   logic             bg_seen_ff, bg_seen_in;
   logic             err_ff, err_in;
   logic [CNT_W-1:0] col_cnt_ff, col_cnt_in;
   logic [CNT_W-1:0] row_cnt_ff, row_cnt_in;

   logic             emit_ff, emit_in;
   logic             emit_err_ff;
   logic [31:0]      emit_fg_ff;
   logic [31:0]      emit_bg_ff;
   logic [IDX_W-1:0] emit_row_ff, emit_row_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_row_ff;
   logic [PS-1:0]    rsp_pattern_ff;
   logic [31:0]      rsp_fg_ff;
   logic [31:0]      rsp_bg_ff;
   logic             rsp_ok_ff;
   logic             rsp_last_ff;

   logic [PS-1:0]    row_store_ff [PS];

   logic [CNT_W-1:0] width;
   logic [CNT_W-1:0] height;
   logic             tile;
   logic [PS-1:0]    bit_mask;
   logic [PS-1:0]    keep_mask;
   logic [PS-1:0]    acc_upd;
   logic [31:0]      fg_upd;
   logic [31:0]      bg_upd;
   logic             fg_seen_upd;
   logic             bg_seen_upd;
   logic             err_upd;
   logic [CNT_W-1:0] col_inc;
   logic [CNT_W-1:0] row_inc;
   logic             row_done;
   logic             run_done;
   logic [PS-1:0]    row_val;
   logic [PS-1:0]    fold;
   logic [PS-1:0]    rot;
   logic             rsp_load;
   logic [IDX_W-1:0] src_row;
   logic [IDX_W-1:0] height_mask;

   assign width    = size_of(cfg.width_log2);
   assign height   = size_of(cfg.height_log2);
   assign tile     = (cfg.mode == tspb_pkg::MODE_TILE);
   assign bit_mask = {1'b1, {(PS-1){1'b0}}} >> col_cnt_ff[IDX_W-1:0];
   assign keep_mask = ~({PS{1'b1}} >> width);
   assign col_inc  = col_cnt_ff + CNT_W'(1);
   assign row_inc  = row_cnt_ff + CNT_W'(1);

   // Two-colour classification of one pixel.
   always_comb begin
      acc_upd     = acc_ff;
      fg_upd      = fg_ff;
      bg_upd      = bg_ff;
      fg_seen_upd = fg_seen_ff;
      bg_seen_upd = bg_seen_ff;
      err_upd     = err_ff;
      if (fg_seen_ff && in_word_ff == fg_ff) begin
         acc_upd = acc_ff | bit_mask;
      end else if (!bg_seen_ff || in_word_ff != bg_ff) begin
         if (!fg_seen_ff) begin
            fg_seen_upd = 1'b1;
            fg_upd      = in_word_ff;
            acc_upd     = acc_ff | bit_mask;
         end else if (!bg_seen_ff) begin
            bg_seen_upd = 1'b1;
            bg_upd      = in_word_ff;
         end else begin
            err_upd = 1'b1;
         end
      end
   end

   assign row_done = in_valid_ff && (!tile || col_inc >= width);
   assign run_done = row_done && (row_inc >= height);
   assign row_val  = tile ? acc_upd : (in_word_ff & keep_mask);

   // Replicate the row across the word, then rotate it right.
   always_comb begin
      fold = row_val;
      for (int k = 0; k < IDX_W; k++) begin
         if ((CNT_W'(1) << k) >= width) begin
            fold = fold | (fold >> (1 << k));
         end
      end
      rot = fold;
      if (cfg.x_offset != '0) begin
         rot = (fold >> cfg.x_offset) | (fold << (CNT_W'(PS) - {1'b0, cfg.x_offset}));
      end
   end

   assign req_bus.ready = !emit_ff && !run_done;

   always_comb begin
      acc_in     = acc_ff;
      fg_in      = fg_ff;
      bg_in      = bg_ff;
      fg_seen_in = fg_seen_ff;
      bg_seen_in = bg_seen_ff;
      err_in     = err_ff;
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (in_valid_ff) begin
         if (tile) begin
            fg_in      = fg_upd;
            bg_in      = bg_upd;
            fg_seen_in = fg_seen_upd;
            bg_seen_in = bg_seen_upd;
            err_in     = err_upd;
            acc_in     = row_done ? '0 : acc_upd;
            col_cnt_in = row_done ? '0 : col_inc;
         end
         if (row_done) begin
            row_cnt_in = row_inc;
         end
         if (run_done) begin
            acc_in     = '0;
            fg_in      = '0;
            bg_in      = '0;
            fg_seen_in = 1'b0;
            bg_seen_in = 1'b0;
            err_in     = 1'b0;
            col_cnt_in = '0;
            row_cnt_in = '0;
         end
      end
   end

   assign rsp_load    = emit_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign height_mask = IDX_W'(height - CNT_W'(1));
   assign src_row     = (emit_row_ff - cfg.y_offset) & height_mask;

   always_comb begin
      emit_in      = emit_ff;
      emit_row_in  = emit_row_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         emit_row_in  = emit_row_ff + IDX_W'(1);
         if (emit_err_ff || emit_row_ff == IDX_W'(PS - 1)) begin
            emit_in = 1'b0;
         end
      end
      if (run_done) begin
         emit_in     = 1'b1;
         emit_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         fg_ff        <= '0;
         bg_ff        <= '0;
         fg_seen_ff   <= 1'b0;
         bg_seen_ff   <= 1'b0;
         err_ff       <= 1'b0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         emit_ff      <= 1'b0;
         emit_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= req_bus.valid && req_bus.ready;
         acc_ff       <= acc_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         fg_seen_ff   <= fg_seen_in;
         bg_seen_ff   <= bg_seen_in;
         err_ff       <= err_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         emit_ff      <= emit_in;
         emit_row_ff  <= emit_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_word_ff <= req_bus.source_word;
      end
      if (run_done) begin
         emit_err_ff <= tile ? err_upd : err_ff;
         emit_fg_ff  <= tile ? fg_upd : '0;
         emit_bg_ff  <= tile ? bg_upd : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (row_done) begin
         row_store_ff[row_cnt_ff[IDX_W-1:0]] <= rot;
      end
      if (rsp_load) begin
         if (emit_err_ff) begin
            rsp_row_ff     <= '0;
            rsp_pattern_ff <= '0;
            rsp_fg_ff      <= '0;
            rsp_bg_ff      <= '0;
            rsp_ok_ff      <= 1'b0;
            rsp_last_ff    <= 1'b1;
         end else begin
            rsp_row_ff     <= emit_row_ff;
            rsp_pattern_ff <= row_store_ff[src_row];
            rsp_fg_ff      <= emit_fg_ff;
            rsp_bg_ff      <= emit_bg_ff;
            rsp_ok_ff      <= 1'b1;
            rsp_last_ff    <= (emit_row_ff == IDX_W'(PS - 1));
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.row_index    = rsp_row_ff;
   assign rsp_bus.pattern_word = rsp_pattern_ff;
   assign rsp_bus.fg_color     = rsp_fg_ff;
   assign rsp_bus.bg_color     = rsp_bg_ff;
   assign rsp_bus.ok           = rsp_ok_ff;
   assign rsp_bus.last         = rsp_last_ff;

   a_no_accept_while_emitting: assert property (
      @(posedge clock) disable iff (reset) emit_ff |-> !req_bus.ready
   ) else $error("Input beat accepted while pattern rows are being emitted.");

   a_error_beat_is_last: assert property (
      @(posedge clock) disable iff (reset) (rsp_valid_ff && !rsp_ok_ff) |-> rsp_last_ff
   ) else $error("Error result beat is not marked last.");

   a_last_ends_emission: assert property (
      @(posedge clock) disable iff (reset) (rsp_load && rsp_valid_in && emit_err_ff) |=> !emit_ff
   ) else $error("Emission continued after the error beat.");

   a_row_count_bound: assert property (
      @(posedge clock) disable iff (reset) row_cnt_ff < CNT_W'(PS)
   ) else $error("Row counter left its range.");

   a_col_count_bound: assert property (
      @(posedge clock) disable iff (reset) col_cnt_ff < CNT_W'(PS)
   ) else $error("Column counter left its range.");

endmodule
